// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define MEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after antecedent
`define MEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/meb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meb_pkg
// Shared types, constants and helpers of the escape-time unit.
// ----------------------------------------------------------------------------
package meb_pkg;

  localparam int FRACTION_BITS = 28;
  localparam int COORD_W       = 32;
  localparam int STEP_W        = 31;
  localparam int PIX_W         = 10;
  localparam int CNT_W         = 16;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int EXT_W         = PROD_W + 1;
  localparam int CFG_IDX_W     = 2;

  localparam bit                CAN_ESCAPE = (2 * FRACTION_BITS + 2) <= 63;
  localparam logic [PROD_W-1:0] THRESHOLD  =
    CAN_ESCAPE ? (PROD_W'(4) << (2 * FRACTION_BITS)) : '0;

  localparam logic signed [COORD_W-1:0] X_MIN_RST    = 32'shE000_0000;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST    = 32'shE800_0000;
  localparam logic        [STEP_W-1:0]  STEP_RST     = 31'h000C_0000;
  localparam logic        [CNT_W-1:0]   MAX_ITER_RST = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN,
    REG_Y_MIN,
    REG_PIXEL_STEP,
    REG_MAX_ITER
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_COL_STEP,
    MUL_ROW_STEP,
    MUL_ZR_ZR,
    MUL_ZI_ZI,
    MUL_ZR_ZI
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_COL,
    ST_MUL_ROW,
    ST_LOAD_CI,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     start;
    mul_sel_e mul_sel;
    logic     load_cr;
    logic     load_ci;
    logic     save_rr;
    logic     save_diff;
    logic     update;
    logic     load_result;
  } ctrl_t;

  typedef struct packed {
    logic escape;
    logic at_limit;
    logic at_limit_next;
    logic out_free;
  } status_t;

  // clamp a wide signed value to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[EXT_W-1:COORD_W-1] == {(EXT_W-COORD_W+1){v[EXT_W-1]}}) begin
      r = v[COORD_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/meb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meb_datapath
// Config registers, shared 32x32 multiplier, z/c registers and result item.
// ----------------------------------------------------------------------------
module meb_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [meb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [meb_pkg::COORD_W-1:0]          cfg_data_i,
  input  logic [meb_pkg::PIX_W-1:0]            pixel_row_i,
  input  logic [meb_pkg::PIX_W-1:0]            pixel_col_i,
  input  meb_pkg::ctrl_t                       ctrl_i,
  output meb_pkg::status_t                     status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [meb_pkg::CNT_W-1:0]            escape_count_o
);

  logic signed [meb_pkg::COORD_W-1:0] x_min_q, y_min_q;
  logic        [meb_pkg::STEP_W-1:0]  step_q;
  logic        [meb_pkg::CNT_W-1:0]   max_iter_q;

  logic [meb_pkg::PIX_W-1:0] row_q, col_q;
  logic signed [meb_pkg::COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [meb_pkg::PROD_W-1:0]  prod_q, rr_q, diff_q;
  logic [meb_pkg::CNT_W-1:0] count_q;
  logic [meb_pkg::CNT_W-1:0] result_q;
  logic                      out_valid_q;

  logic signed [meb_pkg::COORD_W-1:0] mul_a, mul_b;
  logic signed [meb_pkg::EXT_W-1:0]   pt_r, pt_i, re_sh, im_sh, nr, ni;
  logic        [meb_pkg::PROD_W-1:0]  mag2;
  logic        [meb_pkg::CNT_W:0]     count_inc;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= meb_pkg::X_MIN_RST;
      y_min_q    <= meb_pkg::Y_MIN_RST;
      step_q     <= meb_pkg::STEP_RST;
      max_iter_q <= meb_pkg::MAX_ITER_RST;
    end else if (cfg_valid_i) begin
      unique case (meb_pkg::cfg_reg_e'(cfg_index_i))
        meb_pkg::REG_X_MIN:      x_min_q    <= cfg_data_i;
        meb_pkg::REG_Y_MIN:      y_min_q    <= cfg_data_i;
        meb_pkg::REG_PIXEL_STEP: step_q     <= cfg_data_i[meb_pkg::STEP_W-1:0];
        meb_pkg::REG_MAX_ITER:   max_iter_q <= cfg_data_i[meb_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = zr_q;
    mul_b = zr_q;
    unique case (ctrl_i.mul_sel)
      meb_pkg::MUL_COL_STEP: begin
        mul_a = {{(meb_pkg::COORD_W-meb_pkg::PIX_W){1'b0}}, col_q};
        mul_b = {1'b0, step_q};
      end
      meb_pkg::MUL_ROW_STEP: begin
        mul_a = {{(meb_pkg::COORD_W-meb_pkg::PIX_W){1'b0}}, row_q};
        mul_b = {1'b0, step_q};
      end
      meb_pkg::MUL_ZR_ZR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      meb_pkg::MUL_ZI_ZI: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      meb_pkg::MUL_ZR_ZI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    pt_r  = $signed({prod_q[meb_pkg::PROD_W-1], prod_q})
          + $signed({{(meb_pkg::EXT_W-meb_pkg::COORD_W){x_min_q[meb_pkg::COORD_W-1]}}, x_min_q});
    pt_i  = $signed({prod_q[meb_pkg::PROD_W-1], prod_q})
          + $signed({{(meb_pkg::EXT_W-meb_pkg::COORD_W){y_min_q[meb_pkg::COORD_W-1]}}, y_min_q});
    re_sh = $signed({diff_q[meb_pkg::PROD_W-1], diff_q}) >>> meb_pkg::FRACTION_BITS;
    im_sh = $signed({prod_q[meb_pkg::PROD_W-1], prod_q}) >>> (meb_pkg::FRACTION_BITS - 1);
    nr    = re_sh
          + $signed({{(meb_pkg::EXT_W-meb_pkg::COORD_W){cr_q[meb_pkg::COORD_W-1]}}, cr_q});
    ni    = im_sh
          + $signed({{(meb_pkg::EXT_W-meb_pkg::COORD_W){ci_q[meb_pkg::COORD_W-1]}}, ci_q});
    mag2  = $unsigned(rr_q) + $unsigned(prod_q);
    count_inc = {1'b0, count_q} + (meb_pkg::CNT_W+1)'(1);
  end

  always_comb begin
    status_o.escape        = meb_pkg::CAN_ESCAPE && (mag2 >= meb_pkg::THRESHOLD);
    status_o.at_limit      = count_q >= max_iter_q;
    status_o.at_limit_next = count_inc >= {1'b0, max_iter_q};
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (ctrl_i.start) begin
      row_q   <= pixel_row_i;
      col_q   <= pixel_col_i;
      count_q <= meb_pkg::CNT_W'(1);
    end
    if (ctrl_i.load_cr) begin
      cr_q <= meb_pkg::sat_coord(pt_r);
      zr_q <= meb_pkg::sat_coord(pt_r);
    end
    if (ctrl_i.load_ci) begin
      ci_q <= meb_pkg::sat_coord(pt_i);
      zi_q <= meb_pkg::sat_coord(pt_i);
    end
    if (ctrl_i.save_rr) begin
      rr_q <= prod_q;
    end
    if (ctrl_i.save_diff) begin
      diff_q <= rr_q - prod_q;
    end
    if (ctrl_i.update) begin
      zr_q    <= meb_pkg::sat_coord(nr);
      zi_q    <= meb_pkg::sat_coord(ni);
      count_q <= count_inc[meb_pkg::CNT_W-1:0];
    end
    if (ctrl_i.load_result) begin
      result_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = result_q;

endmodule

// ----- design/meb_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meb_seq
// Sequencer: pixel point set-up, then four steps per iteration.
// ----------------------------------------------------------------------------
module meb_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  meb_pkg::status_t status_i,
  output meb_pkg::ctrl_t   ctrl_o
);

  meb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= meb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      meb_pkg::ST_IDLE:    if (in_valid_i) state_d = meb_pkg::ST_MUL_COL;
      meb_pkg::ST_MUL_COL: state_d = meb_pkg::ST_MUL_ROW;
      meb_pkg::ST_MUL_ROW: state_d = meb_pkg::ST_LOAD_CI;
      meb_pkg::ST_LOAD_CI: begin
        state_d = status_i.at_limit ? meb_pkg::ST_DONE : meb_pkg::ST_MUL_RR;
      end
      meb_pkg::ST_MUL_RR:  state_d = meb_pkg::ST_MUL_II;
      meb_pkg::ST_MUL_II:  state_d = meb_pkg::ST_MUL_RI;
      meb_pkg::ST_MUL_RI: begin
        state_d = status_i.escape ? meb_pkg::ST_DONE : meb_pkg::ST_UPDATE;
      end
      meb_pkg::ST_UPDATE: begin
        state_d = status_i.at_limit_next ? meb_pkg::ST_DONE : meb_pkg::ST_MUL_RR;
      end
      meb_pkg::ST_DONE:    if (status_i.out_free) state_d = meb_pkg::ST_IDLE;
      default:             state_d = meb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    ctrl_o.mul_sel = meb_pkg::MUL_ZR_ZR;
    unique case (state_q)
      meb_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.start = in_valid_i;
      end
      meb_pkg::ST_MUL_COL: ctrl_o.mul_sel = meb_pkg::MUL_COL_STEP;
      meb_pkg::ST_MUL_ROW: begin
        ctrl_o.mul_sel = meb_pkg::MUL_ROW_STEP;
        ctrl_o.load_cr = 1'b1;
      end
      meb_pkg::ST_LOAD_CI: ctrl_o.load_ci = 1'b1;
      meb_pkg::ST_MUL_RR:  ctrl_o.mul_sel = meb_pkg::MUL_ZR_ZR;
      meb_pkg::ST_MUL_II: begin
        ctrl_o.mul_sel = meb_pkg::MUL_ZI_ZI;
        ctrl_o.save_rr = 1'b1;
      end
      meb_pkg::ST_MUL_RI: begin
        ctrl_o.mul_sel   = meb_pkg::MUL_ZR_ZI;
        ctrl_o.save_diff = 1'b1;
      end
      meb_pkg::ST_UPDATE:  ctrl_o.update = 1'b1;
      meb_pkg::ST_DONE:    ctrl_o.load_result = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one pixel, Q4.28 fixed point, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : pixel_row_i / pixel_col_i, taken on in_valid_i & in_ready_o.
//   out channel : escape_count_o, given on out_valid_o & out_ready_i.
//   cfg channel : cfg_index_i selects x_min, y_min, pixel_step, max_iterations;
//                 cfg_ready_o is always high. Write only while idle.
// Timing: one item at a time. After an item is taken, the col*step and row*step
//   products form c; each iteration then takes zr*zr, zi*zi and zr*zi in turn
//   from the single 32x32 multiplier and updates z, an escaping test ending
//   after the zr*zi step, and a last step loads the result register.
//   in_ready_o is high again the cycle after the result is loaded.
// Stall: a waiting result sits in the output register while the next item
//   is taken; a finished item holds in its last step until that register
//   frees up.
// Reset: registers return to their default view (x_min -2.0, y_min -1.5,
//   step 3/1024, 256 iterations), no item in flight, no result valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mandelbrot_escape_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [meb_pkg::PIX_W-1:0]     pixel_row_i,
  input  logic [meb_pkg::PIX_W-1:0]     pixel_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [meb_pkg::CNT_W-1:0]     escape_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [meb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [meb_pkg::COORD_W-1:0]   cfg_data_i
);

  meb_pkg::ctrl_t   ctrl;
  meb_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  meb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  meb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .escape_count_o (escape_count_o)
  );

  `MEB_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `MEB_ASSERT(a_count_nonzero, out_valid_o |-> (escape_count_o != '0), "zero escape count")
  `MEB_ASSERT(a_result_from_seq, $rose(out_valid_o) |-> $past(ctrl.load_result), "stray result")

endmodule

// ----- verif/tb_mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Self-checking bench for the escape-time unit. A directed table covers the
// reset view, the register extremes, saturation of the pixel point, the
// magnitude threshold and the iteration limit. Random views and pixels follow,
// under several idling patterns and one long output hold-off. Every result is
// checked against a fixed count from the table or a fixed-point predictor.
// ----------------------------------------------------------------------------

module tb_mandelbrot_escape_time;

  localparam logic [meb_pkg::COORD_W-1:0] Q_ONE      = 32'h1000_0000;
  localparam logic [meb_pkg::COORD_W-1:0] Q_TWO      = 32'h2000_0000;
  localparam logic [meb_pkg::COORD_W-1:0] RST_X      = 32'hE000_0000;
  localparam logic [meb_pkg::COORD_W-1:0] RST_Y      = 32'hE800_0000;
  localparam logic [meb_pkg::COORD_W-1:0] RST_STEP   = 32'h000C_0000;
  localparam logic [meb_pkg::COORD_W-1:0] RST_ITERS  = 32'd256;
  localparam int                          HOLD_OFF   = 400;
  localparam int                          PHASE_LEN  = 50;
  localparam int                          NUM_PHASES = 8;
  localparam int                          STALL_MAX  = 1_200_000;

  typedef struct packed {
    logic [meb_pkg::COORD_W-1:0] x;
    logic [meb_pkg::COORD_W-1:0] y;
    logic [meb_pkg::COORD_W-1:0] s;
    logic [meb_pkg::COORD_W-1:0] m;
    logic [meb_pkg::PIX_W-1:0]   row;
    logic [meb_pkg::PIX_W-1:0]   col;
    logic                        known;
    logic [meb_pkg::CNT_W-1:0]   count;
  } pixel_case_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic [meb_pkg::PIX_W-1:0]   pixel_row_i    = '0;
  logic [meb_pkg::PIX_W-1:0]   pixel_col_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [meb_pkg::CNT_W-1:0]   escape_count_o;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  meb_pkg::cfg_reg_e           cfg_index_i    = meb_pkg::REG_X_MIN;
  logic [meb_pkg::COORD_W-1:0] cfg_data_i     = '0;

  logic signed [meb_pkg::COORD_W-1:0] view_x_min = RST_X;
  logic signed [meb_pkg::COORD_W-1:0] view_y_min = RST_Y;
  logic [meb_pkg::STEP_W-1:0]         view_step  = RST_STEP[meb_pkg::STEP_W-1:0];
  logic [meb_pkg::CNT_W-1:0]          view_iters = RST_ITERS[meb_pkg::CNT_W-1:0];

  logic [meb_pkg::CNT_W-1:0] pending_counts [$];
  logic [meb_pkg::CNT_W-1:0] want_count;
  int                        error_count   = 0;
  int                        stall_cycles  = 0;
  int unsigned               tx_idle_pct   = 0;
  int unsigned               rx_idle_pct   = 0;
  bit                        pressure_req  = 1'b0;
  bit                        pressure_done = 1'b0;
  int                        hold_left     = 0;

  pixel_case_t directed_cases [23] = '{
    '{RST_X, RST_Y, RST_STEP, RST_ITERS, 10'd0, 10'd0, 1'b1, 16'd1},
    '{RST_X, RST_Y, RST_STEP, RST_ITERS, 10'd1023, 10'd1023, 1'b0, 16'd0},
    '{RST_X, RST_Y, RST_STEP, RST_ITERS, 10'd512, 10'd683, 1'b0, 16'd0},
    '{RST_X, RST_Y, RST_STEP, RST_ITERS, 10'd341, 10'd300, 1'b0, 16'd0},
    '{32'd0, 32'd0, 32'd0, 32'd256, 10'd0, 10'd0, 1'b1, 16'd256},
    '{32'd0, 32'd0, 32'd0, 32'd256, 10'd1023, 10'd1023, 1'b1, 16'd256},
    '{32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 10'd0, 10'd0, 1'b1, 16'd1},
    '{32'd0, 32'd0, 32'd0, 32'd1, 10'd0, 10'd0, 1'b1, 16'd1},
    '{32'd0, 32'd0, 32'd0, 32'h0001_0002, 10'd0, 10'd0, 1'b1, 16'd2},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd256, 10'd1023, 10'd1023,
      1'b1, 16'd1},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd256, 10'd0, 10'd0,
      1'b1, 16'd1},
    '{32'h8000_0000, 32'h8000_0000, 32'd0, 32'd256, 10'd5, 10'd9, 1'b1, 16'd1},
    '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'd256, 10'd0, 10'd1023,
      1'b1, 16'd1},
    '{Q_TWO, 32'd0, 32'd0, 32'd256, 10'd0, 10'd0, 1'b1, 16'd1},
    '{-Q_TWO, 32'd0, 32'd0, 32'd256, 10'd0, 10'd0, 1'b1, 16'd1},
    '{32'd0, Q_TWO, 32'd0, 32'd256, 10'd0, 10'd0, 1'b1, 16'd1},
    '{Q_TWO - 1, 32'd0, 32'd0, 32'd256, 10'd0, 10'd0, 1'b0, 16'd0},
    '{1 - Q_TWO, 32'd0, 32'd0, 32'd256, 10'd0, 10'd0, 1'b0, 16'd0},
    '{32'd0, 1 - Q_TWO, 32'd0, 32'd256, 10'd0, 10'd0, 1'b0, 16'd0},
    '{-Q_ONE, 32'd0, 32'd0, 32'd100, 10'd0, 10'd0, 1'b0, 16'd0},
    '{RST_X, RST_Y, RST_STEP, 32'hFFFF, 10'd0, 10'd0, 1'b1, 16'd1},
    '{RST_X, RST_Y, RST_STEP, 32'hFFFF, 10'd1023, 10'd0, 1'b0, 16'd0},
    '{32'd0, 32'd0, 32'd0, 32'hFFFF, 10'd0, 10'd0, 1'b1, 16'd65535}
  };

  mandelbrot_escape_time dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .escape_count_o (escape_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_coord(input longint v);
    longint r;
    r = v;
    if (v > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (v < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
    return r;
  endfunction

  function automatic logic [meb_pkg::CNT_W-1:0] escape_count_of(
      input logic [meb_pkg::PIX_W-1:0] row, input logic [meb_pkg::PIX_W-1:0] col);
    longint                    cr, ci, zr, zi, rr, ii, ri;
    longint unsigned           mag, limit;
    bit                        may_escape;
    logic [meb_pkg::CNT_W-1:0] count;
    may_escape = (2 * meb_pkg::FRACTION_BITS + 2) <= 63;
    limit      = may_escape ? (64'd4 << (2 * meb_pkg::FRACTION_BITS)) : 64'd0;
    cr    = clamp_coord(longint'(view_x_min) + longint'(col) * longint'(view_step));
    ci    = clamp_coord(longint'(view_y_min) + longint'(row) * longint'(view_step));
    zr    = cr;
    zi    = ci;
    count = meb_pkg::CNT_W'(1);
    for (int k = 1; k < int'(view_iters); k++) begin
      rr  = zr * zr;
      ii  = zi * zi;
      ri  = zr * zi;
      mag = longint'(rr) + longint'(ii);
      if (may_escape && mag >= limit) break;
      count++;
      zr = clamp_coord(((rr - ii) >>> meb_pkg::FRACTION_BITS) + cr);
      zi = clamp_coord((ri >>> (meb_pkg::FRACTION_BITS - 1)) + ci);
    end
    return count;
  endfunction

  task automatic report_mismatch(input string what, input logic [meb_pkg::CNT_W-1:0] got,
                                 input logic [meb_pkg::CNT_W-1:0] want);
    $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input meb_pkg::cfg_reg_e idx,
                           input logic [meb_pkg::COORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      meb_pkg::REG_X_MIN:      view_x_min = data;
      meb_pkg::REG_Y_MIN:      view_y_min = data;
      meb_pkg::REG_PIXEL_STEP: view_step  = data[meb_pkg::STEP_W-1:0];
      meb_pkg::REG_MAX_ITER:   view_iters = data[meb_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  // registers only change with the unit idle
  task automatic load_view(input logic [meb_pkg::COORD_W-1:0] x,
                           input logic [meb_pkg::COORD_W-1:0] y,
                           input logic [meb_pkg::COORD_W-1:0] s,
                           input logic [meb_pkg::COORD_W-1:0] m);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    write_reg(meb_pkg::REG_X_MIN, x);
    write_reg(meb_pkg::REG_Y_MIN, y);
    write_reg(meb_pkg::REG_PIXEL_STEP, s);
    write_reg(meb_pkg::REG_MAX_ITER, m);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [meb_pkg::PIX_W-1:0] row,
                            input logic [meb_pkg::PIX_W-1:0] col,
                            input logic known, input logic [meb_pkg::CNT_W-1:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_row_i <= row;
    pixel_col_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
    pending_counts.push_back(known ? count : escape_count_of(row, col));
  endtask

  always @(posedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_OFF;
      out_ready_i   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("result with no item pending", escape_count_o, '0);
        end else begin
          want_count = pending_counts.pop_front();
          if (escape_count_o !== want_count) begin
            report_mismatch("escape_count", escape_count_o, want_count);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("timeout: no handshake for %0d cycles", stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [meb_pkg::COORD_W-1:0] vx, vy, vs, vm;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      if (directed_cases[i].x != view_x_min || directed_cases[i].y != view_y_min ||
          directed_cases[i].s[meb_pkg::STEP_W-1:0] != view_step ||
          directed_cases[i].m[meb_pkg::CNT_W-1:0] != view_iters) begin
        load_view(directed_cases[i].x, directed_cases[i].y,
                  directed_cases[i].s, directed_cases[i].m);
      end
      send_pixel(directed_cases[i].row, directed_cases[i].col,
                 directed_cases[i].known, directed_cases[i].count);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if ($urandom_range(3) == 0) begin
        // arbitrary view, mostly saturated points
        vx = $urandom;
        vy = $urandom;
        vs = $urandom;
        vm = ($urandom & 32'hFFFF_0000) | $urandom_range(40);
      end else begin
        vx = -$urandom_range(32'h2800_0000, 32'h0800_0000);
        vy = -$urandom_range(32'h1800_0000, 32'h0400_0000);
        vs = $urandom_range(32'h000C_0000, 32'h400) | ($urandom & 32'h8000_0000);
        vm = ($urandom_range(7) == 0) ? 32'd256 : $urandom_range(64, 2);
      end
      load_view(vx, vy, vs, vm);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 77; end
        default: begin tx_idle_pct = 14; rx_idle_pct = 14; end
      endcase
      if (ph == 0) pressure_req = 1'b1;
      repeat (PHASE_LEN) begin
        send_pixel(meb_pkg::PIX_W'($urandom_range(1023)),
                   meb_pkg::PIX_W'($urandom_range(1023)), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      report_mismatch("item left without result", '0, pending_counts[0]);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
